### rtl/ioeu_pkg.sv
package ioeu_pkg;

  // Instruction classes after decode. CLS_PASS covers the NOP forms and every
  // opcode not handled here: registers and status go through untouched.
  typedef enum logic [3:0] {
    CLS_PASS,
    CLS_SLO,
    CLS_RLA,
    CLS_SRE,
    CLS_RRA,
    CLS_DCP,
    CLS_ISB,
    CLS_ALR,
    CLS_ANC,
    CLS_ANE,
    CLS_SBX,
    CLS_USBC,
    CLS_LAS,
    CLS_LAX,
    CLS_SAX,
    CLS_JAM
  } ioeu_cls_t;

  typedef struct packed {
    ioeu_cls_t   cls;
    logic [1:0]  step;
    logic [3:0]  cyc;
    logic        pg_pen;
  } ioeu_dec_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  sp;
    logic [7:0]  status;
    logic [7:0]  store_data;
    logic        store_enable;
    logic [1:0]  pc_step;
    logic [3:0]  cycle_count;
    logic        jam;
  } ioeu_res_t;

endpackage

### rtl/ioeu_decode.sv
module ioeu_decode
  import ioeu_pkg::*;
(
  input  logic [7:0] opcode,
  output ioeu_dec_t  dec
);

  logic [2:0] grp;
  logic [4:0] low5;
  logic       rmw_grp;
  logic       rmw_ok;
  logic [1:0] rmw_step;
  logic [3:0] rmw_cyc;

  assign grp  = opcode[7:5];
  assign low5 = opcode[4:0];

  // The read-modify-write families live in every opcode group but the two
  // load/store groups.
  assign rmw_grp = (grp inside {3'd0, 3'd1, 3'd2, 3'd3, 3'd6, 3'd7});

  always_comb begin
    rmw_ok   = 1'b1;
    rmw_step = 2'd2;
    rmw_cyc  = 4'd5;
    case (low5)
      5'h07: begin rmw_step = 2'd2; rmw_cyc = 4'd5; end
      5'h17: begin rmw_step = 2'd2; rmw_cyc = 4'd6; end
      5'h0F: begin rmw_step = 2'd3; rmw_cyc = 4'd6; end
      5'h1F: begin rmw_step = 2'd3; rmw_cyc = 4'd7; end
      5'h1B: begin rmw_step = 2'd3; rmw_cyc = 4'd7; end
      5'h03: begin rmw_step = 2'd2; rmw_cyc = 4'd8; end
      5'h13: begin rmw_step = 2'd2; rmw_cyc = 4'd8; end
      default: rmw_ok = 1'b0;
    endcase
  end

  always_comb begin
    dec.cls    = CLS_PASS;
    dec.step   = 2'd1;
    dec.cyc    = 4'd2;
    dec.pg_pen = 1'b0;
    if (rmw_grp && rmw_ok) begin
      dec.step = rmw_step;
      dec.cyc  = rmw_cyc;
      case (grp)
        3'd0:    dec.cls = CLS_SLO;
        3'd1:    dec.cls = CLS_RLA;
        3'd2:    dec.cls = CLS_SRE;
        3'd3:    dec.cls = CLS_RRA;
        3'd6:    dec.cls = CLS_DCP;
        default: dec.cls = CLS_ISB;
      endcase
    end else if ((low5 == 5'h12) ||
                 (opcode inside {8'h02, 8'h22, 8'h42, 8'h62})) begin
      dec.cls  = CLS_JAM;
      dec.step = 2'd0;
      dec.cyc  = 4'd0;
    end else begin
      case (opcode)
        8'h4B: begin dec.cls = CLS_ALR; dec.step = 2'd2; end
        8'h0B, 8'h2B: begin dec.cls = CLS_ANC; dec.step = 2'd2; end
        8'h8B: begin dec.cls = CLS_ANE; dec.step = 2'd2; end
        8'hCB: begin dec.cls = CLS_SBX; dec.step = 2'd2; end
        8'hEB: begin dec.cls = CLS_USBC; dec.step = 2'd2; end
        8'hBB: begin
          dec.cls = CLS_LAS; dec.step = 2'd3; dec.cyc = 4'd4; dec.pg_pen = 1'b1;
        end
        8'hA7: begin dec.cls = CLS_LAX; dec.step = 2'd2; dec.cyc = 4'd3; end
        8'hB7: begin dec.cls = CLS_LAX; dec.step = 2'd2; dec.cyc = 4'd4; end
        8'hAF: begin dec.cls = CLS_LAX; dec.step = 2'd3; dec.cyc = 4'd4; end
        8'hBF: begin
          dec.cls = CLS_LAX; dec.step = 2'd3; dec.cyc = 4'd4; dec.pg_pen = 1'b1;
        end
        8'hA3: begin dec.cls = CLS_LAX; dec.step = 2'd2; dec.cyc = 4'd6; end
        8'hB3: begin
          dec.cls = CLS_LAX; dec.step = 2'd2; dec.cyc = 4'd5; dec.pg_pen = 1'b1;
        end
        8'h87: begin dec.cls = CLS_SAX; dec.step = 2'd2; dec.cyc = 4'd3; end
        8'h97: begin dec.cls = CLS_SAX; dec.step = 2'd2; dec.cyc = 4'd4; end
        8'h8F: begin dec.cls = CLS_SAX; dec.step = 2'd3; dec.cyc = 4'd4; end
        8'h83: begin dec.cls = CLS_SAX; dec.step = 2'd2; dec.cyc = 4'd6; end
        8'h80, 8'h82, 8'h89, 8'hC2, 8'hE2: begin
          dec.step = 2'd2; dec.cyc = 4'd2;
        end
        8'h04, 8'h44, 8'h64: begin dec.step = 2'd2; dec.cyc = 4'd3; end
        8'h14, 8'h34, 8'h54, 8'h74, 8'hD4, 8'hF4: begin
          dec.step = 2'd2; dec.cyc = 4'd4;
        end
        8'h0C: begin dec.step = 2'd3; dec.cyc = 4'd4; end
        8'h1C, 8'h3C, 8'h5C, 8'h7C, 8'hDC, 8'hFC: begin
          dec.step = 2'd3; dec.cyc = 4'd4; dec.pg_pen = 1'b1;
        end
        default: begin
          dec.step = 2'd1; dec.cyc = 4'd2;
        end
      endcase
    end
  end

endmodule

### rtl/ioeu_alu.sv
module ioeu_alu
  import ioeu_pkg::*;
(
  input  ioeu_dec_t  dec,
  input  logic [7:0] operand,
  input  logic [7:0] acc_in,
  input  logic [7:0] x_in,
  input  logic [7:0] sp_in,
  input  logic [7:0] status_in,
  input  logic       page_crossed,
  output ioeu_res_t  res
);

  localparam int FlagC = 0;
  localparam int FlagV = 6;

  function automatic logic [7:0] with_zn(input logic [7:0] st, input logic [7:0] v);
    logic [7:0] o;
    o    = st;
    o[1] = (v == 8'h00);
    o[7] = v[7];
    return o;
  endfunction

  logic       c_in;
  logic [7:0] slo_r, rla_r, sre_r, rra_r, dcp_r, isb_r;
  logic [8:0] rra_sum;
  logic [7:0] sub_m;
  logic [8:0] sub_d;
  logic       sub_v;
  logic [7:0] dcp_diff;
  logic [7:0] sbx_t, sbx_r;
  logic [7:0] and_am;
  logic [7:0] st;

  assign c_in  = status_in[FlagC];
  assign slo_r = {operand[6:0], 1'b0};
  assign rla_r = {operand[6:0], c_in};
  assign sre_r = {1'b0, operand[7:1]};
  assign rra_r = {c_in, operand[7:1]};
  assign dcp_r = operand - 8'd1;
  assign isb_r = operand + 8'd1;

  assign rra_sum = {1'b0, acc_in} + {1'b0, rra_r} + {8'd0, operand[0]};

  // One subtract-with-borrow serves both USBC and the second half of ISB.
  assign sub_m = (dec.cls == CLS_ISB) ? isb_r : operand;
  assign sub_d = {1'b0, acc_in} + {1'b0, ~sub_m} + {8'd0, c_in};
  assign sub_v = (acc_in[7] ^ sub_d[7]) & (acc_in[7] ^ sub_m[7]);

  assign dcp_diff = acc_in - dcp_r;
  assign sbx_t    = acc_in & x_in;
  assign sbx_r    = sbx_t - operand;
  assign and_am   = acc_in & operand;

  always_comb begin
    res.acc          = acc_in;
    res.x            = x_in;
    res.sp           = sp_in;
    res.status       = status_in;
    res.store_data   = 8'h00;
    res.store_enable = 1'b0;
    res.pc_step      = dec.step;
    res.cycle_count  = dec.cyc + {3'd0, dec.pg_pen & page_crossed};
    res.jam          = 1'b0;
    st               = status_in;
    case (dec.cls)
      CLS_SLO: begin
        st[FlagC] = operand[7];
        res.acc = acc_in | slo_r;
        res.status = with_zn(st, acc_in | slo_r);
        res.store_data = slo_r; res.store_enable = 1'b1;
      end
      CLS_RLA: begin
        st[FlagC] = operand[7];
        res.acc = acc_in & rla_r;
        res.status = with_zn(st, acc_in & rla_r);
        res.store_data = rla_r; res.store_enable = 1'b1;
      end
      CLS_SRE: begin
        st[FlagC] = operand[0];
        res.acc = acc_in ^ sre_r;
        res.status = with_zn(st, acc_in ^ sre_r);
        res.store_data = sre_r; res.store_enable = 1'b1;
      end
      CLS_RRA: begin
        st[FlagC] = rra_sum[8];
        st[FlagV] = ~(acc_in[7] ^ rra_r[7]) & (acc_in[7] ^ rra_sum[7]);
        res.acc = rra_sum[7:0];
        res.status = with_zn(st, rra_sum[7:0]);
        res.store_data = rra_r; res.store_enable = 1'b1;
      end
      CLS_DCP: begin
        st[FlagC] = (acc_in >= dcp_r);
        res.status = with_zn(st, dcp_diff);
        res.store_data = dcp_r; res.store_enable = 1'b1;
      end
      CLS_ISB, CLS_USBC: begin
        st[FlagC] = sub_d[8];
        st[FlagV] = sub_v;
        res.acc = sub_d[7:0];
        res.status = with_zn(st, sub_d[7:0]);
        if (dec.cls == CLS_ISB) begin
          res.store_data = isb_r; res.store_enable = 1'b1;
        end
      end
      CLS_ALR: begin
        st[FlagC] = and_am[0];
        res.acc = {1'b0, and_am[7:1]};
        res.status = with_zn(st, {1'b0, and_am[7:1]});
      end
      CLS_ANC: begin
        st[FlagC] = and_am[7];
        res.acc = and_am;
        res.status = with_zn(st, and_am);
      end
      CLS_ANE: begin
        res.acc = and_am & x_in;
        res.status = with_zn(st, and_am & x_in);
      end
      CLS_SBX: begin
        st[FlagC] = (sbx_t >= operand);
        res.x = sbx_r;
        res.status = with_zn(st, sbx_r);
      end
      CLS_LAS: begin
        res.acc = operand & sp_in;
        res.x   = operand & sp_in;
        res.sp  = operand & sp_in;
        res.status = with_zn(st, operand & sp_in);
      end
      CLS_LAX: begin
        res.acc = operand;
        res.x   = operand;
        res.status = with_zn(st, operand);
      end
      CLS_SAX: begin
        res.store_data = sbx_t; res.store_enable = 1'b1;
      end
      CLS_JAM: begin
        res.jam = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/illegal_opcode_execute_unit.sv
// Channel   Valid / ready            Payload
// request   in_valid / in_ready      in_req_type, in_operand, in_acc_in, in_x_in,
//                                    in_sp_in, in_status_in, in_page_crossed
// result    out_valid / out_ready    out_acc_out, out_x_out, out_sp_out,
//                                    out_status_out, out_store_data,
//                                    out_store_enable, out_pc_step,
//                                    out_cycle_count, out_jam
//
// One request per cycle while in_ready is high; a taken request goes into the
// request register, then through decode and ALU into the result register.
// Synchronous active-low reset empties both registers.
// A stalled result holds the result register; the request register keeps
// taking requests until both stages are full.
module illegal_opcode_execute_unit
  import ioeu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_req_type,
  input  logic [7:0] in_operand,
  input  logic [7:0] in_acc_in,
  input  logic [7:0] in_x_in,
  input  logic [7:0] in_sp_in,
  input  logic [7:0] in_status_in,
  input  logic       in_page_crossed,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_acc_out,
  output logic [7:0] out_x_out,
  output logic [7:0] out_sp_out,
  output logic [7:0] out_status_out,
  output logic [7:0] out_store_data,
  output logic       out_store_enable,
  output logic [1:0] out_pc_step,
  output logic [3:0] out_cycle_count,
  output logic       out_jam
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] op_r, operand_r, acc_r, x_r, sp_r, status_r;
  logic       pg_r;
  logic       out_valid_r, out_valid_nxt;
  ioeu_res_t  res_r;
  ioeu_dec_t  dec;
  ioeu_res_t  res;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_free;

  ioeu_decode u_decode (
    .opcode (op_r),
    .dec    (dec)
  );

  ioeu_alu u_alu (
    .dec          (dec),
    .operand      (operand_r),
    .acc_in       (acc_r),
    .x_in         (x_r),
    .sp_in        (sp_r),
    .status_in    (status_r),
    .page_crossed (pg_r),
    .res          (res)
  );

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r      <= in_req_type;
      operand_r <= in_operand;
      acc_r     <= in_acc_in;
      x_r       <= in_x_in;
      sp_r      <= in_sp_in;
      status_r  <= in_status_in;
      pg_r      <= in_page_crossed;
    end
    if (out_free && s1_valid_r) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_acc_out      = res_r.acc;
  assign out_x_out        = res_r.x;
  assign out_sp_out       = res_r.sp;
  assign out_status_out   = res_r.status;
  assign out_store_data   = res_r.store_data;
  assign out_store_enable = res_r.store_enable;
  assign out_pc_step      = res_r.pc_step;
  assign out_cycle_count  = res_r.cycle_count;
  assign out_jam          = res_r.jam;

`ifndef SYNTHESIS
  a_no_bubble_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("request stage stalled while result side was ready");

  a_held_request: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r)
    else $error("pending request dropped during result stall");

  a_jam_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_jam |-> (out_pc_step == 2'd0) && (out_cycle_count == 4'd0)
                             && !out_store_enable)
    else $error("jam result advances or stores");

  a_idle_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_store_enable |-> (out_store_data == 8'h00))
    else $error("store data set without store enable");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_valid_r)
    else $error("pipeline not empty after reset");
`endif

endmodule
